// File: hdl/fbpa_pkg.sv
// Package for the fixed block pool allocator: field widths, request and
// status codes, and the command codes passed from the front end to the back end.
// No dependencies.
package fbpa_pkg;

  // Default sizing of the pool.
  localparam int unsigned MAX_BLOCKS_DEF      = 64;
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 4096;

  // Smallest block: one link word.
  localparam int unsigned MARKER_BYTES = 8;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths.
  localparam int unsigned BS_CFG_W  = 13;
  localparam int unsigned BIU_W     = 7;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned SIZE_W    = 19;
  localparam int unsigned OFF_W     = 18;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_OOM         = 3'd1,
    ST_TOO_BIG     = 3'd2,
    ST_BAD_OFFSET  = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_e;

  // Classified commands handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_NOP        = 3'd3,
    OP_TOO_BIG    = 3'd4,
    OP_BAD_OFFSET = 3'd5
  } op_e;

endpackage

// File: hdl/fixed_block_pool_allocator.sv
// Fixed block pool allocator. Allocate, clear and rejected requests pass through the
// front end, the command queue and the back end; a free also waits for the offset
// division and then walks the free list one element per cycle (up to MAX_BLOCKS).
// The back end starts a new command only after finishing the last; the free-list walk is the slowest.
// Reset: head at block zero, all link valid bits cleared so the chain reads as
// 0,1,...,MAX_BLOCKS-1; no clearing pass. Depends on fbpa_pkg and all fbpa modules.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS      = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = fbpa_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbpa_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fbpa_pkg::REQ_W-1:0]      req_type_i,
  input  logic [fbpa_pkg::SIZE_W-1:0]     request_size_i,
  input  logic [fbpa_pkg::OFF_W-1:0]      free_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fbpa_pkg::STATUS_W-1:0]   status_o,
  output logic [fbpa_pkg::OFF_W-1:0]      block_offset_o
);
  import fbpa_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned BSW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned CW  = (BSW > BS_CFG_W) ? BSW : BS_CFG_W;
  localparam int unsigned QW  = $bits(op_e) + IW;

  logic [BS_CFG_W-1:0] cfg_bs_q;
  logic [BIU_W-1:0]    cfg_blocks_q;
  logic [CW-1:0]       bs_raw;
  logic [BSW-1:0]      bs_eff;

  logic          q_push, q_full, q_pop, q_valid;
  op_e           f_op;
  logic [IW-1:0] f_idx;
  logic [QW-1:0] q_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bs_q     <= BS_CFG_W'(MARKER_BYTES);
      cfg_blocks_q <= BIU_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_SIZE:    cfg_bs_q     <= cfg_data_i[BS_CFG_W-1:0];
        CFG_BLOCKS_IN_USE: cfg_blocks_q <= cfg_data_i[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Block size clamped to MARKER_BYTES..MAX_BLOCK_BYTES.
  assign bs_raw = CW'(cfg_bs_q);
  assign bs_eff = (bs_raw < CW'(MARKER_BYTES)) ? BSW'(MARKER_BYTES) :
                  (bs_raw > CW'(MAX_BLOCK_BYTES)) ? BSW'(MAX_BLOCK_BYTES) : BSW'(bs_raw);

  fbpa_front #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .request_size_i (request_size_i),
    .free_offset_i  (free_offset_i),
    .block_size_i   (bs_eff),
    .push_o         (q_push),
    .full_i         (q_full),
    .op_o           (f_op),
    .idx_o          (f_idx)
  );

  fbpa_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_op, f_idx}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  fbpa_back #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_op_i         (op_e'(q_data[QW-1:IW])),
    .q_idx_i        (q_data[IW-1:0]),
    .block_size_i   (bs_eff),
    .blocks_cfg_i   (cfg_blocks_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .block_offset_o (block_offset_o)
  );

  // The back end never takes a command while its result beat is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !(out_valid_o && out_stall_i))
    else $error("command popped while result beat is stalled");

  // The front end only pushes into a queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full command queue");

  // A stalled input beat means the front end still holds an earlier one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_stall_o || q_push || $past(q_full) == 1'b0))
    else $error("front end stalled without a held beat");

  // Only a successful result carries a nonzero block offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (block_offset_o == '0))
    else $error("nonzero offset on a failed request");

endmodule

// File: hdl/fbpa_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle.
// Depends on fbpa_pkg for the offset width.
module fbpa_divider #(
  parameter int unsigned DIVISOR_W = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fbpa_pkg::OFF_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]       divisor_i,
  output logic                       done_o,
  output logic [fbpa_pkg::OFF_W-1:0] quotient_o,
  output logic                       rem_zero_o
);
  import fbpa_pkg::*;

  localparam int unsigned CNT_W = $clog2(OFF_W + 1);

  logic                 busy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] div_q;
  logic [OFF_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W:0]   trial;
  logic                 take;

  // One step: bring down the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem_q, quo_q[OFF_W-1]};
    take  = (trial >= {1'b0, div_q});
    rem_d = take ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
    quo_d = {quo_q[OFF_W-2:0], take};
  end

  // Control: count the steps of one division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(OFF_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: remainder and the shared dividend/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

// File: hdl/fbpa_front.sv
// Front end: accepts request beats, checks sizes and offsets, and hands
// classified commands to the queue. Depends on fbpa_pkg and fbpa_divider.
module fbpa_front #(
  parameter int unsigned MAX_BLOCKS      = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = fbpa_pkg::MAX_BLOCK_BYTES_DEF,
  localparam int unsigned IW  = $clog2(MAX_BLOCKS),
  localparam int unsigned BSW = $clog2(MAX_BLOCK_BYTES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fbpa_pkg::REQ_W-1:0]  req_type_i,
  input  logic [fbpa_pkg::SIZE_W-1:0] request_size_i,
  input  logic [fbpa_pkg::OFF_W-1:0]  free_offset_i,
  input  logic [BSW-1:0]              block_size_i,
  output logic                        push_o,
  input  logic                        full_i,
  output fbpa_pkg::op_e               op_o,
  output logic [IW-1:0]               idx_o
);
  import fbpa_pkg::*;

  localparam int unsigned SW = (SIZE_W > BSW) ? SIZE_W : BSW;

  logic             hold_valid_q;
  logic             hold_free_q;
  op_e              hold_op_q;
  op_e              op_in;
  logic             accept;
  logic             ready;
  logic             div_done;
  logic [OFF_W-1:0] quotient;
  logic             rem_zero;
  logic             in_range;

  // Classify a request as it arrives; frees are settled after the division.
  always_comb begin
    case (req_type_i)
      REQ_ALLOC: op_in = (SW'(request_size_i) > SW'(block_size_i)) ? OP_TOO_BIG : OP_ALLOC;
      REQ_FREE:  op_in = OP_FREE;
      REQ_CLEAR: op_in = OP_CLEAR;
      default:   op_in = OP_NOP;
    endcase
  end

  // Offset to block index.
  fbpa_divider #(
    .DIVISOR_W (BSW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && (req_type_i == REQ_FREE)),
    .dividend_i (free_offset_i),
    .divisor_i  (block_size_i),
    .done_o     (div_done),
    .quotient_o (quotient),
    .rem_zero_o (rem_zero)
  );

  assign in_range = (quotient < OFF_W'(MAX_BLOCKS));
  assign ready    = hold_valid_q && (!hold_free_q || div_done);
  assign push_o   = ready && !full_i;
  assign in_stall_o = hold_valid_q && !push_o;
  assign accept   = in_valid_i && !in_stall_o;

  // Command going to the queue.
  always_comb begin
    if (hold_free_q) begin
      op_o = (rem_zero && in_range) ? OP_FREE : OP_BAD_OFFSET;
    end else begin
      op_o = hold_op_q;
    end
    idx_o = quotient[IW-1:0];
  end

  // Holding register for the beat in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (accept) begin
      hold_valid_q <= 1'b1;
    end else if (push_o) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_op_q   <= op_in;
      hold_free_q <= (req_type_i == REQ_FREE);
    end
  end

endmodule

// File: hdl/fbpa_queue.sv
// Short FIFO of classified commands between front end and back end.
// Depends on fbpa_pkg for its depth.
module fbpa_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import fbpa_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/fbpa_back.sv
// Back end: owns the free list (head register, link memory, valid bits),
// executes commands one at a time and drives the result register.
// Depends on fbpa_pkg.
module fbpa_back #(
  parameter int unsigned MAX_BLOCKS      = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = fbpa_pkg::MAX_BLOCK_BYTES_DEF,
  localparam int unsigned IW  = $clog2(MAX_BLOCKS),
  localparam int unsigned BSW = $clog2(MAX_BLOCK_BYTES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  fbpa_pkg::op_e                 q_op_i,
  input  logic [IW-1:0]                 q_idx_i,
  input  logic [BSW-1:0]                block_size_i,
  input  logic [fbpa_pkg::BIU_W-1:0]    blocks_cfg_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fbpa_pkg::STATUS_W-1:0] status_o,
  output logic [fbpa_pkg::OFF_W-1:0]    block_offset_o
);
  import fbpa_pkg::*;

  localparam int unsigned LW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NW = (LW > BIU_W) ? LW : BIU_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [LW-1:0]   head_q, head_d;
  logic [LW-1:0]   pool_q, pool_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   step_q, step_d;
  logic            first_q, first_d;
  logic [OFF_W-1:0] prod_q;
  logic [IW+BSW-1:0] prod_full;
  logic            prod_we;

  logic [LW-1:0]   link_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_q;
  logic [IW-1:0]   rd_addr;
  logic [LW-1:0]   rd_data_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  logic [LW-1:0]   rd_next;
  logic [LW-1:0]   link_eff;
  logic [LW-1:0]   cur;
  logic [NW-1:0]   n_raw;
  logic [LW-1:0]   pool_n;

  logic            clear_all;
  logic            mem_we;
  logic            res_we;
  status_e         res_status;
  logic [OFF_W-1:0] res_offset;
  logic            out_free;

  logic            out_valid_q;
  status_e         status_q;
  logic [OFF_W-1:0] offset_q;

  // A link that was never written since the last clear reads as the rebuilt chain.
  assign rd_next  = LW'(rd_idx_q) + LW'(1);
  assign link_eff = rd_vld_q ? rd_data_q : ((rd_next < pool_q) ? rd_next : NULL_LINK);

  // Pool size taken at a clear, clamped to 1..MAX_BLOCKS.
  assign n_raw  = NW'(blocks_cfg_i);
  assign pool_n = (n_raw == '0) ? LW'(1) :
                  (n_raw > NW'(MAX_BLOCKS)) ? NULL_LINK : LW'(n_raw);

  assign prod_full = head_q[IW-1:0] * block_size_i;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cur       = first_q ? head_q : link_eff;

  // Command sequencer.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    pool_d     = pool_q;
    idx_d      = idx_q;
    step_d     = step_q;
    first_d    = first_q;
    prod_we    = 1'b0;
    clear_all  = 1'b0;
    mem_we     = 1'b0;
    res_we     = 1'b0;
    res_status = ST_OK;
    res_offset = '0;
    rd_addr    = head_q[IW-1:0];
    q_pop_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_op_i)
            OP_ALLOC: begin
              if (head_q >= NULL_LINK) begin
                res_we     = 1'b1;
                res_status = ST_OOM;
              end else begin
                prod_we = 1'b1;
                state_d = S_ALLOC;
              end
            end
            OP_FREE: begin
              if (LW'(q_idx_i) >= pool_q) begin
                res_we     = 1'b1;
                res_status = ST_BAD_OFFSET;
              end else begin
                idx_d   = q_idx_i;
                step_d  = '0;
                first_d = 1'b1;
                state_d = S_WALK;
              end
            end
            OP_CLEAR: begin
              clear_all = 1'b1;
              pool_d    = pool_n;
              head_d    = '0;
              res_we    = 1'b1;
            end
            OP_TOO_BIG: begin
              res_we     = 1'b1;
              res_status = ST_TOO_BIG;
            end
            OP_BAD_OFFSET: begin
              res_we     = 1'b1;
              res_status = ST_BAD_OFFSET;
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end

      // Link of the popped block has arrived: advance the head.
      S_ALLOC: begin
        head_d     = link_eff;
        res_we     = 1'b1;
        res_offset = prod_q;
        state_d    = S_IDLE;
      end

      // One free-list element per cycle; the read of the next link overlaps the check.
      S_WALK: begin
        first_d = 1'b0;
        if ((cur >= NULL_LINK) || (step_q == IW'(MAX_BLOCKS - 1) && cur[IW-1:0] != idx_q)) begin
          mem_we  = 1'b1;
          head_d  = LW'(idx_q);
          res_we  = 1'b1;
          state_d = S_IDLE;
        end else if (cur[IW-1:0] == idx_q) begin
          res_we     = 1'b1;
          res_status = ST_DOUBLE_FREE;
          state_d    = S_IDLE;
        end else begin
          rd_addr = cur[IW-1:0];
          step_d  = step_q + IW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and link valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      pool_q      <= NULL_LINK;
      first_q     <= 1'b0;
      step_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      pool_q  <= pool_d;
      first_q <= first_d;
      step_q  <= step_d;
      if (clear_all) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Link memory with registered read, plus datapath registers.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[idx_q] <= head_q;
    end
    rd_data_q <= link_mem[rd_addr];
    rd_vld_q  <= valid_q[rd_addr];
    rd_idx_q  <= rd_addr;
    idx_q     <= idx_d;
    if (prod_we) begin
      prod_q <= OFF_W'(prod_full);
    end
    if (res_we) begin
      status_q <= res_status;
      offset_q <= res_offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_offset_o = offset_q;

endmodule

// File: bench/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 100ps
// Testbench for fixed_block_pool_allocator: directed and random allocate, free and clear
// requests, checked against a shadow free list kept in a small scoreboard class.
// Depends on fbpa_pkg and the allocator RTL.
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int unsigned POOL_MAX       = MAX_BLOCKS_DEF;
  localparam int unsigned BLOCK_MAX      = MAX_BLOCK_BYTES_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 102;
  localparam int unsigned REPORT_MAX     = 10;

  // One reply beat as the allocator should produce it.
  typedef struct packed {
    status_e              status;
    logic [OFF_W-1:0]     offset;
  } reply_t;

  // Shadow copy of the pool: configuration, link memory, head and pool size, plus
  // the queue of replies still owed by the block.
  class pool_scoreboard;
    int unsigned cfg_block_size;
    int unsigned cfg_blocks_in_use;
    int unsigned shadow_link[POOL_MAX];
    int unsigned shadow_head;
    int unsigned shadow_pool;
    reply_t      pending_replies[$];
    int unsigned failures;
    int unsigned replies_checked;
    int unsigned status_seen[5];

    function new();
      cfg_block_size    = 8;
      cfg_blocks_in_use = 64;
      failures          = 0;
      replies_checked   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      rebuild_chain();
    endfunction

    // Block size as the block uses it, clamped to one link word and the maximum.
    function int unsigned eff_block_size();
      if (cfg_block_size < MARKER_BYTES) return MARKER_BYTES;
      if (cfg_block_size > BLOCK_MAX) return BLOCK_MAX;
      return cfg_block_size;
    endfunction

    // A clear takes the pool size from the register and chains 0,1,...,n-1.
    function void rebuild_chain();
      int unsigned n;
      n = cfg_blocks_in_use;
      if (n < 1) n = 1;
      if (n > POOL_MAX) n = POOL_MAX;
      shadow_pool = n;
      for (int unsigned i = 0; i < POOL_MAX; i++)
        shadow_link[i] = (i + 1 < n) ? i + 1 : POOL_MAX;
      shadow_head = 0;
    endfunction

    // Walk the free list from the head, at most one step per block.
    function bit on_free_list(int unsigned idx);
      int unsigned cur;
      cur = shadow_head;
      for (int unsigned step = 0; step < POOL_MAX; step++) begin
        if (cur >= POOL_MAX) return 1'b0;
        if (cur == idx) return 1'b1;
        cur = shadow_link[cur];
      end
      return 1'b0;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_BLOCK_SIZE) cfg_block_size = 32'(data);
      else cfg_blocks_in_use = 32'(data[BIU_W-1:0]);
    endfunction

    // A block inside the pool that is currently handed out, or -1 if none is.
    function int pick_taken_block();
      int taken[$];
      for (int unsigned i = 0; i < shadow_pool; i++)
        if (!on_free_list(i)) taken.push_back(i);
      if (taken.size() == 0) return -1;
      return taken[$urandom_range(0, taken.size() - 1)];
    endfunction

    // Update the shadow pool for an accepted request and queue the reply it owes.
    function void note_request(logic [REQ_W-1:0] req, logic [SIZE_W-1:0] size,
                               logic [OFF_W-1:0] off);
      int unsigned bs;
      int unsigned idx;
      reply_t want;
      bs = eff_block_size();
      want.status = ST_OK;
      want.offset = '0;
      case (req)
        REQ_ALLOC: begin
          if (size > bs) want.status = ST_TOO_BIG;
          else if (shadow_head >= POOL_MAX) want.status = ST_OOM;
          else begin
            want.offset = OFF_W'(shadow_head * bs);
            shadow_head = shadow_link[shadow_head];
          end
        end
        REQ_FREE: begin
          idx = off / bs;
          if (off % bs != 0 || idx >= shadow_pool) want.status = ST_BAD_OFFSET;
          else if (on_free_list(idx)) want.status = ST_DOUBLE_FREE;
          else begin
            shadow_link[idx] = shadow_head;
            shadow_head = idx;
          end
        end
        REQ_CLEAR: rebuild_chain();
        default: ;
      endcase
      pending_replies.push_back(want);
    endfunction

    function void report_failure(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Compare a reply beat with the oldest owed reply, field by field.
    function void check_reply(logic [STATUS_W-1:0] got_status, logic [OFF_W-1:0] got_offset);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_failure($sformatf("reply status=%0d offset=%0d with no request pending",
                                 got_status, got_offset));
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      status_seen[int'(want.status)]++;
      if (got_status !== want.status)
        report_failure($sformatf("reply %0d: status expected %0d, got %0d",
                                 replies_checked, want.status, got_status));
      if (got_offset !== want.offset)
        report_failure($sformatf("reply %0d: block_offset expected %0d, got %0d",
                                 replies_checked, want.offset, got_offset));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DAT_W-1:0]  cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i;
  logic [SIZE_W-1:0]     request_size_i;
  logic [OFF_W-1:0]      free_offset_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [OFF_W-1:0]      block_offset_o;

  pool_scoreboard sb = new();

  int unsigned idle_cycles  = 0;
  int unsigned items_sent   = 0;
  int unsigned configs_done = 0;
  int unsigned holdoffs     = 0;
  int unsigned burst_left   = 1;
  bit          steady_mode  = 1'b0;
  bit          holdoff_req  = 1'b0;

  fixed_block_pool_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .request_size_i (request_size_i),
    .free_offset_i  (free_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .block_offset_o (block_offset_o)
  );

  // 4 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check reply beats and count cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_reply(status_o, block_offset_o);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // End the run if the block stops moving beats.
  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("FAIL fixed_block_pool_allocator");
    $finish;
  end

  // Reply side: stall patterns drawn anew for each run, and a long
  // hold-off on request so that the block backs up into its request port.
  initial begin : reply_pacing
    int unsigned mode;
    int unsigned run;
    int unsigned period;
    int unsigned k;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        holdoffs++;
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end
      mode   = $urandom_range(0, 3);
      run    = $urandom_range(20, 150);
      period = $urandom_range(2, 8);
      k      = 0;
      while (k < run && !holdoff_req) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((k % period) < period / 2);
        endcase
        k++;
        @(posedge clk_i);
      end
    end
  end

  // Offer one request beat, record it when accepted, then apply the burst pacing.
  task automatic issue(input logic [REQ_W-1:0] req, input logic [SIZE_W-1:0] size,
                       input logic [OFF_W-1:0] off);
    req_type_i     <= req;
    request_size_i <= size;
    free_offset_i  <= off;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(req, size, off);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!steady_mode) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every owed reply has come back.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_replies.size() != 0);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(input logic [CFG_DAT_W-1:0] bs, input logic [CFG_DAT_W-1:0] biu);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BLOCK_SIZE;
    cfg_data_i  <= bs;
    @(posedge clk_i);
    sb.write_cfg(CFG_BLOCK_SIZE, bs);
    cfg_index_i <= CFG_BLOCKS_IN_USE;
    cfg_data_i  <= biu;
    @(posedge clk_i);
    sb.write_cfg(CFG_BLOCKS_IN_USE, biu);
    cfg_we_i <= 1'b0;
    configs_done++;
  endtask

  // Mostly allocations and frees of blocks that are really handed out; the rest are
  // oversize requests, stray offsets, double frees, clears and the unused code.
  task automatic pick_request(input int unsigned alloc_pct, output logic [REQ_W-1:0] req,
                              output logic [SIZE_W-1:0] size, output logic [OFF_W-1:0] off);
    int unsigned bs;
    int unsigned roll;
    int taken;
    bs   = sb.eff_block_size();
    roll = $urandom_range(0, 99);
    size = SIZE_W'($urandom);
    off  = OFF_W'($urandom);
    if (roll < alloc_pct) begin
      req = REQ_ALLOC;
      case ($urandom_range(0, 9))
        0:       size = SIZE_W'(bs);
        1:       size = SIZE_W'(bs + 1 + $urandom_range(0, 3));
        2:       size = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
        default: size = SIZE_W'($urandom_range(0, bs));
      endcase
    end else if (roll < 94) begin
      req   = REQ_FREE;
      taken = sb.pick_taken_block();
      case ($urandom_range(0, 19))
        0, 1, 2: off = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
        3, 4:    off = OFF_W'($urandom_range(0, sb.shadow_pool + 2) * bs);
        default: begin
          if (taken >= 0) off = OFF_W'(taken * bs);
          else off = OFF_W'($urandom_range(0, sb.shadow_pool - 1) * bs);
        end
      endcase
    end else if (roll < 97) begin
      req = REQ_CLEAR;
    end else begin
      req = REQ_UNUSED;
    end
  endtask

  initial begin : stimulus
    int unsigned phase_bs[PHASES];
    int unsigned phase_biu[PHASES];
    int unsigned alloc_pct;
    logic [REQ_W-1:0]  req;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;

    phase_bs       = '{8, 0, 4096, 8191, 7, 24, 1000, 0, 0, 0};
    phase_biu      = '{64, 1, 64, 127, 2, 5, 0, 0, 0, 0};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_BLOCK_SIZE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_ALLOC;
    request_size_i = '0;
    free_offset_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: 8-byte blocks, 64 of them.
    issue(REQ_ALLOC, 19'd0, '0);
    issue(REQ_ALLOC, 19'd8, '0);
    issue(REQ_ALLOC, 19'd9, '0);
    issue(REQ_ALLOC, '1, '0);
    issue(REQ_FREE, '0, 18'd0);
    issue(REQ_FREE, '0, 18'd0);
    issue(REQ_FREE, '0, 18'd3);
    issue(REQ_FREE, '0, 18'd512);
    issue(REQ_FREE, '0, '1);
    issue(REQ_FREE, '0, 18'd8);
    issue(REQ_UNUSED, '1, '1);
    issue(REQ_ALLOC, 19'd8, '0);
    issue(REQ_CLEAR, '0, '0);

    // Block size zero acts as one link word; the pool is set to a single block.
    set_config(13'd0, 13'd1);
    issue(REQ_CLEAR, '0, '0);
    issue(REQ_ALLOC, 19'd0, '0);
    issue(REQ_ALLOC, 19'd0, '0);
    issue(REQ_FREE, '0, 18'd8);
    issue(REQ_FREE, '0, 18'd0);

    // Oversize register values clamp to the largest block and the full pool.
    set_config(13'd8191, 13'd127);
    issue(REQ_CLEAR, '0, '0);
    issue(REQ_ALLOC, 19'd4096, '0);
    issue(REQ_ALLOC, 19'd4097, '0);
    issue(REQ_FREE, '0, 18'd258048);
    issue(REQ_FREE, '0, 18'd0);
    issue(REQ_FREE, '0, 18'd6);

    // Random phases, each under its own pool setting.
    for (int unsigned p = 7; p < PHASES; p++) begin
      phase_bs[p]  = $urandom_range(0, 8191);
      phase_biu[p] = $urandom_range(0, 127);
    end
    for (int unsigned p = 0; p < PHASES; p++) begin
      set_config(CFG_DAT_W'(phase_bs[p]), CFG_DAT_W'(phase_biu[p]));
      steady_mode = ($urandom_range(0, 3) == 0);
      alloc_pct   = $urandom_range(40, 62);
      // One phase keeps the old pool size to show the count waits for a clear.
      if (p != 5) issue(REQ_CLEAR, '0, '0);
      if (p == 2) holdoff_req = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        pick_request(alloc_pct, req, size, off);
        issue(req, size, off);
        if (p == 4 && i == PHASE_ITEMS / 2) wait_drain();
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_replies.size() != 0)
      sb.report_failure($sformatf("%0d replies never arrived", sb.pending_replies.size()));

    $display("Summary: %0d requests over %0d pool settings, %0d replies checked, %0d failures.",
             items_sent, configs_done + 1, sb.replies_checked, sb.failures);
    $display("Status: ok %0d, oom %0d, big %0d, bad off %0d, dbl free %0d; hold-offs %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], holdoffs);
    if (sb.failures == 0) begin
      $display("PASS fixed_block_pool_allocator");
    end else begin
      $display("FAIL fixed_block_pool_allocator");
    end
    $finish;
  end

endmodule
